// ===== hdl/pulse_peak_detector_core_macros.svh =====
// Assertion macros shared by the pulse peak detector RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef PULSE_PEAK_DETECTOR_CORE_MACROS_SVH
`define PULSE_PEAK_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define PPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pulse peak detector: assertion failed");

`define PPD_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("pulse peak detector: forbidden condition seen");

`else

`define PPD_ASSERT(label, prop)
`define PPD_ASSERT_NEVER(label, expr)

`endif

`endif

// ===== hdl/ppd_pkg.sv =====
package ppd_pkg;

  localparam int SAMPLE_BITS   = 20;
  localparam int TIME_BITS     = 32;
  localparam int AMP_BITS      = 20;
  localparam int RISE_BITS     = 16;
  localparam int FALL_BITS     = 16;
  localparam int MIN_AMP_BITS  = 20;
  localparam int REFR_BITS     = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Compare width: covers sample +/- threshold and peak - valley against min_amplitude
  localparam int CMP_W = ((SAMPLE_BITS > MIN_AMP_BITS) ? SAMPLE_BITS : MIN_AMP_BITS) + 2;

  localparam int IN_TDATA_W  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((AMP_BITS + 7) / 8) * 8;

  localparam logic [AMP_BITS-1:0] AMP_MAX = {AMP_BITS{1'b1}};

  localparam logic [CFG_IDX_BITS-1:0] REG_RISE_THRESHOLD = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FALL_THRESHOLD = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_AMPLITUDE  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOFF_MS     = CFG_IDX_BITS'(3);

  localparam logic [RISE_BITS-1:0]    RISE_RESET    = RISE_BITS'(20);
  localparam logic [FALL_BITS-1:0]    FALL_RESET    = FALL_BITS'(20);
  localparam logic [MIN_AMP_BITS-1:0] MIN_AMP_RESET = MIN_AMP_BITS'(45);
  localparam logic [REFR_BITS-1:0]    REFR_RESET    = REFR_BITS'(350);

  typedef struct packed {
    logic [RISE_BITS-1:0]    rise_threshold;
    logic [FALL_BITS-1:0]    fall_threshold;
    logic [MIN_AMP_BITS-1:0] min_amplitude;
    logic [REFR_BITS-1:0]    holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic                beat_flag;
    logic [AMP_BITS-1:0] beat_amp;
  } result_t;

  typedef struct packed {
    logic primed;
    logic climbing;
  } status_t;

endpackage

// ===== hdl/ppd_cfg_regs.sv =====
module ppd_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [ppd_pkg::CFG_IDX_BITS-1:0]   wr_index_i,
  input  logic [ppd_pkg::CFG_DATA_BITS-1:0]  wr_data_i,
  output ppd_pkg::cfg_t                      cfg_o
);

  ppd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      // Keep only the low bits of each register; drop writes past the list
      case (wr_index_i)
        ppd_pkg::REG_RISE_THRESHOLD:
          cfg_d.rise_threshold = wr_data_i[ppd_pkg::RISE_BITS-1:0];
        ppd_pkg::REG_FALL_THRESHOLD:
          cfg_d.fall_threshold = wr_data_i[ppd_pkg::FALL_BITS-1:0];
        ppd_pkg::REG_MIN_AMPLITUDE:
          cfg_d.min_amplitude = wr_data_i[ppd_pkg::MIN_AMP_BITS-1:0];
        ppd_pkg::REG_HOLDOFF_MS:
          cfg_d.holdoff_ms = wr_data_i[ppd_pkg::REFR_BITS-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_threshold <= ppd_pkg::RISE_RESET;
      cfg_q.fall_threshold <= ppd_pkg::FALL_RESET;
      cfg_q.min_amplitude  <= ppd_pkg::MIN_AMP_RESET;
      cfg_q.holdoff_ms     <= ppd_pkg::REFR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/ppd_tracker.sv =====
module ppd_tracker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   step_i,
  input  logic signed [ppd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic        [ppd_pkg::TIME_BITS-1:0]   now_i,
  input  ppd_pkg::cfg_t                          cfg_i,
  output ppd_pkg::result_t                       result_o,
  output ppd_pkg::status_t                       status_o
);

  localparam int SB = ppd_pkg::SAMPLE_BITS;
  localparam int CW = ppd_pkg::CMP_W;

  logic                   primed_q, primed_d;
  logic                   climbing_q, climbing_d;
  logic signed [SB-1:0]   valley_q, valley_d;
  logic signed [SB-1:0]   peak_q, peak_d;
  logic [ppd_pkg::TIME_BITS-1:0] last_beat_q, last_beat_d;

  logic signed [CW-1:0]   s_ext, valley_ext, peak_ext;
  logic signed [CW-1:0]   rise_ext, fall_ext, min_ext, amp_max_ext;
  logic signed [CW-1:0]   amp_ext;
  logic                   rise_hit, fall_hit, amp_ok, time_ok;
  logic [ppd_pkg::TIME_BITS-1:0] elapsed;
  logic [ppd_pkg::AMP_BITS-1:0]  amp_sat;

  assign s_ext       = {{(CW-SB){sample_i[SB-1]}}, sample_i};
  assign valley_ext  = {{(CW-SB){valley_q[SB-1]}}, valley_q};
  assign peak_ext    = {{(CW-SB){peak_q[SB-1]}}, peak_q};
  assign rise_ext    = signed'({{(CW-ppd_pkg::RISE_BITS){1'b0}}, cfg_i.rise_threshold});
  assign fall_ext    = signed'({{(CW-ppd_pkg::FALL_BITS){1'b0}}, cfg_i.fall_threshold});
  assign min_ext     = signed'({{(CW-ppd_pkg::MIN_AMP_BITS){1'b0}}, cfg_i.min_amplitude});
  assign amp_max_ext = signed'({{(CW-ppd_pkg::AMP_BITS){1'b0}}, ppd_pkg::AMP_MAX});

  // A new extreme can never also cross the threshold, so the old levels suffice
  assign rise_hit = s_ext > (valley_ext + rise_ext);
  assign fall_hit = s_ext < (peak_ext - fall_ext);
  assign amp_ext  = peak_ext - valley_ext;
  assign amp_ok   = amp_ext >= min_ext;
  assign elapsed  = now_i - last_beat_q;
  assign time_ok  = elapsed >= {{(ppd_pkg::TIME_BITS-ppd_pkg::REFR_BITS){1'b0}},
                                cfg_i.holdoff_ms};

  always_comb begin
    if (amp_ext < 0) begin
      amp_sat = '0;
    end else if (amp_ext > amp_max_ext) begin
      amp_sat = ppd_pkg::AMP_MAX;
    end else begin
      amp_sat = amp_ext[ppd_pkg::AMP_BITS-1:0];
    end
  end

  always_comb begin
    primed_d    = primed_q;
    climbing_d  = climbing_q;
    valley_d    = valley_q;
    peak_d      = peak_q;
    last_beat_d = last_beat_q;
    result_o    = '0;
    if (!primed_q) begin
      valley_d = sample_i;
      peak_d   = sample_i;
      primed_d = 1'b1;
    end else if (!climbing_q) begin
      if (s_ext < valley_ext) begin
        valley_d = sample_i;
      end
      if (rise_hit) begin
        climbing_d = 1'b1;
        peak_d     = sample_i;
      end
    end else begin
      if (s_ext > peak_ext) begin
        peak_d = sample_i;
      end
      if (fall_hit) begin
        if (amp_ok && time_ok) begin
          result_o.beat_flag = 1'b1;
          result_o.beat_amp  = amp_sat;
          last_beat_d        = now_i;
        end
        // Re-seed and go back to valley tracking
        climbing_d = 1'b0;
        valley_d   = sample_i;
        peak_d     = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      climbing_q  <= 1'b0;
      valley_q    <= '0;
      peak_q      <= '0;
      last_beat_q <= '0;
    end else if (step_i) begin
      primed_q    <= primed_d;
      climbing_q  <= climbing_d;
      valley_q    <= valley_d;
      peak_q      <= peak_d;
      last_beat_q <= last_beat_d;
    end
  end

  assign status_o.primed   = primed_q;
  assign status_o.climbing = climbing_q;

endmodule

// ===== hdl/pulse_peak_detector_core.sv =====
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata: sample, now_ms
// m_axis    out        m_axis_tvalid/tready        tdata: beat_amp; tuser: beat_flag
// cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// Path: each input transaction passes through the input register, then the output register, to m_axis.
// Throughput: one sample per cycle unless m_axis stalls; the tracker updates its levels in the
// cycle a sample leaves the input register, so each sample sees the previous one's state.
// Reset: asynchronous, active low; empties both stages and resets tracker and config state.
// Stalls: a held m_axis stalls the output register, then the input register, then s_axis.
// cfg_ready_o is always high; a write takes effect on the next cycle.
`include "pulse_peak_detector_core_macros.svh"

module pulse_peak_detector_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [19:0] sample, [51:20] now_ms, [55:52] zero
  input  logic [ppd_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [19:0] beat_amp, [23:20] zero
  output logic [ppd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // [0] beat_flag
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ppd_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [ppd_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  localparam int SB = ppd_pkg::SAMPLE_BITS;
  localparam int TB = ppd_pkg::TIME_BITS;

  ppd_pkg::cfg_t    cfg;
  ppd_pkg::result_t result;
  ppd_pkg::status_t status;

  logic                 in_valid_q, in_valid_d;
  logic signed [SB-1:0] in_sample_q;
  logic [TB-1:0]        in_now_q;
  logic                 out_valid_q, out_valid_d;
  ppd_pkg::result_t     out_q;
  logic                 in_xfer, advance;

  assign cfg_ready_o = 1'b1;

  ppd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Move the held sample into the tracker when the output register can take its result
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_sample_q <= s_axis_tdata[SB-1:0];
      in_now_q    <= s_axis_tdata[SB+TB-1:SB];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  ppd_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_sample_q),
    .now_i    (in_now_q),
    .cfg_i    (cfg),
    .result_o (result),
    .status_o (status)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.beat_flag;
  assign m_axis_tdata  = {{(ppd_pkg::OUT_TDATA_W-ppd_pkg::AMP_BITS){1'b0}},
                          out_q.beat_amp};

  `PPD_ASSERT(a_full_stall, in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
  `PPD_ASSERT(a_step_fills_output, advance |=> m_axis_tvalid)
  `PPD_ASSERT_NEVER(a_climb_needs_prime, status.climbing && !status.primed)
  `PPD_ASSERT_NEVER(a_no_beat_no_amp, m_axis_tvalid && !m_axis_tuser && (out_q.beat_amp != '0))

endmodule

// ===== tb/pulse_peak_detector_core_test.sv =====
`timescale 1ns / 1ps

module pulse_peak_detector_core_test;

  localparam int     SB         = ppd_pkg::SAMPLE_BITS;
  localparam int     TB         = ppd_pkg::TIME_BITS;
  localparam int     AB         = ppd_pkg::AMP_BITS;
  localparam int     NUM_REGS   = 4;
  localparam longint SAMPLE_MAX = (longint'(1) << (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [ppd_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [ppd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                              m_axis_tuser;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [ppd_pkg::CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [ppd_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;

  // samples waiting to be offered, beat results still owed by the block
  logic [ppd_pkg::IN_TDATA_W-1:0] pending_samples[$];
  ppd_pkg::result_t               expected_beats[$];

  // tracker state and thresholds as the block should hold them
  logic                                 trk_primed = 1'b0;
  logic                                 trk_climbing = 1'b0;
  logic signed [SB-1:0]                 trk_valley = '0;
  logic signed [SB-1:0]                 trk_peak = '0;
  logic [TB-1:0]                        trk_last_beat_ms = '0;
  logic [ppd_pkg::RISE_BITS-1:0]        thr_rise = ppd_pkg::RISE_RESET;
  logic [ppd_pkg::FALL_BITS-1:0]        thr_fall = ppd_pkg::FALL_RESET;
  logic [ppd_pkg::MIN_AMP_BITS-1:0]     thr_min_amp = ppd_pkg::MIN_AMP_RESET;
  logic [ppd_pkg::REFR_BITS-1:0]        thr_refractory = ppd_pkg::REFR_RESET;

  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  int            tx_gap = 0;
  int            rx_gap = 0;
  logic          rx_hold = 1'b0;
  int            mismatch_count = 0;
  logic [TB-1:0] wall_ms = '0;

  pulse_peak_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ppd_pkg::IN_TDATA_W-1:0] pack_item(input longint smp,
                                                              input logic [TB-1:0] t);
    logic [ppd_pkg::IN_TDATA_W-1:0] word;
    word = '0;
    word[SB-1:0] = SB'(smp);
    word[SB +: TB] = t;
    return word;
  endfunction

  // Advance the valley/peak tracker by one sample and return the beat it reports.
  function automatic ppd_pkg::result_t track_pulse(input logic [ppd_pkg::IN_TDATA_W-1:0] word);
    logic signed [SB-1:0] smp;
    logic [TB-1:0]        now_ms;
    logic [TB-1:0]        elapsed;
    longint               amp;
    ppd_pkg::result_t     res;
    smp = word[SB-1:0];
    now_ms = word[SB +: TB];
    res = '0;
    if (!trk_primed) begin
      trk_valley = smp;
      trk_peak = smp;
      trk_primed = 1'b1;
    end else if (!trk_climbing) begin
      if (smp < trk_valley) trk_valley = smp;
      if (longint'(smp) > longint'(trk_valley) + longint'(thr_rise)) begin
        trk_climbing = 1'b1;
        trk_peak = smp;
      end
    end else begin
      if (smp > trk_peak) trk_peak = smp;
      if (longint'(smp) < longint'(trk_peak) - longint'(thr_fall)) begin
        amp = longint'(trk_peak) - longint'(trk_valley);
        elapsed = now_ms - trk_last_beat_ms;
        if (amp >= longint'(thr_min_amp) && elapsed >= thr_refractory) begin
          res.beat_flag = 1'b1;
          if (amp < 0) res.beat_amp = '0;
          else if (amp > longint'(ppd_pkg::AMP_MAX)) res.beat_amp = ppd_pkg::AMP_MAX;
          else res.beat_amp = AB'(amp);
          trk_last_beat_ms = now_ms;
        end
        trk_climbing = 1'b0;
        trk_valley = smp;
        trk_peak = smp;
      end
    end
    return res;
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $time, what);
  endfunction

  always @(posedge clk_i) begin : sample_driver
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) expected_beats.push_back(track_pulse(s_axis_tdata));
      // hold the current transaction until it is taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if ($urandom_range(0, 99) < tx_idle_pct) begin
          tx_gap = $urandom_range(0, 15);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_samples.pop_front();
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    ppd_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch($sformatf("result with no sample pending: beat %0b amplitude %0d",
                                  m_axis_tuser, m_axis_tdata[AB-1:0]));
        end else begin
          want = expected_beats.pop_front();
          if (m_axis_tuser !== want.beat_flag ||
              m_axis_tdata[AB-1:0] !== want.beat_amp)
            flag_mismatch($sformatf("expected beat %0b amplitude %0d, got beat %0b amplitude %0d",
                                    want.beat_flag, want.beat_amp,
                                    m_axis_tuser, m_axis_tdata[AB-1:0]));
        end
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [ppd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [ppd_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ppd_pkg::REG_RISE_THRESHOLD: thr_rise = data[ppd_pkg::RISE_BITS-1:0];
      ppd_pkg::REG_FALL_THRESHOLD: thr_fall = data[ppd_pkg::FALL_BITS-1:0];
      ppd_pkg::REG_MIN_AMPLITUDE:  thr_min_amp = data[ppd_pkg::MIN_AMP_BITS-1:0];
      ppd_pkg::REG_HOLDOFF_MS:     thr_refractory = data[ppd_pkg::REFR_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
      @(posedge clk_i);
  endtask

  // Clamp to the sample range, sprinkle in the odd garbage transaction, advance time.
  task automatic queue_level(inout longint lvl);
    if (lvl < SAMPLE_MIN) lvl = SAMPLE_MIN;
    else if (lvl > SAMPLE_MAX) lvl = SAMPLE_MAX;
    if ($urandom_range(0, 24) == 0)
      pending_samples.push_back(pack_item(longint'($urandom()), $urandom()));
    wall_ms += $urandom_range(1, 120);
    pending_samples.push_back(pack_item(lvl, wall_ms));
  endtask

  // Triangle pulses scaled to the current thresholds so that both phases get exercised.
  task automatic queue_pulse_train(input int n_items);
    longint scale, swing, step, lvl;
    int     steps;
    scale = longint'(thr_rise);
    if (longint'(thr_fall) > scale) scale = longint'(thr_fall);
    if (longint'(thr_min_amp) > scale) scale = longint'(thr_min_amp);
    scale = scale + 4;
    lvl = longint'($signed(SB'($urandom())));
    while (pending_samples.size() < n_items) begin
      lvl = lvl + longint'($urandom_range(0, 64)) - 32;
      swing = scale / 2 + longint'($urandom_range(0, 2 * int'(scale)));
      steps = $urandom_range(1, 6);
      step = swing / steps;
      repeat (steps) begin
        lvl = lvl + step + longint'($urandom_range(0, 6)) - 3;
        queue_level(lvl);
      end
      repeat (steps) begin
        lvl = lvl - step - longint'($urandom_range(0, 6));
        queue_level(lvl);
      end
    end
  endtask

  task automatic run_phase(input logic [ppd_pkg::RISE_BITS-1:0] rise,
                           input logic [ppd_pkg::FALL_BITS-1:0] fall,
                           input logic [ppd_pkg::MIN_AMP_BITS-1:0] min_amp,
                           input logic [ppd_pkg::REFR_BITS-1:0] refr,
                           input int n_items, input int tx_pct, input int rx_pct);
    wait_drained();
    // junk in the upper data bits must be dropped by the block
    write_reg(ppd_pkg::REG_RISE_THRESHOLD, {16'($urandom()), rise});
    write_reg(ppd_pkg::REG_FALL_THRESHOLD, {16'($urandom()), fall});
    write_reg(ppd_pkg::REG_MIN_AMPLITUDE, {12'($urandom()), min_amp});
    write_reg(ppd_pkg::REG_HOLDOFF_MS, {16'($urandom()), refr});
    write_reg(ppd_pkg::CFG_IDX_BITS'($urandom_range(NUM_REGS, 2 ** ppd_pkg::CFG_IDX_BITS - 1)),
              $urandom());
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    wall_ms = $urandom();
    queue_pulse_train(n_items);
  endtask

  initial begin : stimulus
    int p;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct <= 15;
    rx_idle_pct <= 15;
    // seed at the extremes, then an early beat inside the refractory window
    pending_samples.push_back(pack_item(SAMPLE_MIN, 32'd0));
    pending_samples.push_back(pack_item(SAMPLE_MAX, 32'd10));
    pending_samples.push_back(pack_item(SAMPLE_MIN, 32'd100));
    // full-scale beat exactly one refractory period after time zero
    pending_samples.push_back(pack_item(SAMPLE_MAX, 32'd200));
    pending_samples.push_back(pack_item(SAMPLE_MIN, 32'd350));
    // rise and fall exactly at threshold, then a pulse too small to count
    pending_samples.push_back(pack_item(SAMPLE_MIN + 20, 32'd400));
    pending_samples.push_back(pack_item(SAMPLE_MIN + 21, 32'd410));
    pending_samples.push_back(pack_item(SAMPLE_MIN + 1, 32'd420));
    pending_samples.push_back(pack_item(SAMPLE_MIN, 32'd430));
    // beat just before the time counter wraps
    pending_samples.push_back(pack_item(0, 32'hFFFF_FF00));
    pending_samples.push_back(pack_item(-45, 32'hFFFF_FFFF));
    // across the wrap: one short of refractory, then exactly min amplitude accepted
    pending_samples.push_back(pack_item(0, 32'd5));
    pending_samples.push_back(pack_item(-21, 32'd348));
    pending_samples.push_back(pack_item(24, 32'd349));
    pending_samples.push_back(pack_item(3, 32'd350));
    // widest pulse with a plateau at the top
    pending_samples.push_back(pack_item(SAMPLE_MIN, 32'd360));
    pending_samples.push_back(pack_item(SAMPLE_MAX, 32'd370));
    pending_samples.push_back(pack_item(SAMPLE_MAX, 32'd380));
    pending_samples.push_back(pack_item(SAMPLE_MAX - 1, 32'd390));
    pending_samples.push_back(pack_item(SAMPLE_MAX - 21, 32'd800));

    run_phase('0, '0, '0, '0, 150, 20, 0);
    run_phase('1, '1, '1, '1, 150, 0, 25);
    for (p = 0; p < 5; p++) begin
      if (p == 4)
        run_phase(ppd_pkg::RISE_BITS'($urandom()), ppd_pkg::FALL_BITS'($urandom()),
                  ppd_pkg::MIN_AMP_BITS'($urandom()), ppd_pkg::REFR_BITS'($urandom()),
                  150, 15, 15);
      else
        run_phase(ppd_pkg::RISE_BITS'($urandom_range(0, 300)),
                  ppd_pkg::FALL_BITS'($urandom_range(0, 300)),
                  ppd_pkg::MIN_AMP_BITS'($urandom_range(0, 2000)),
                  ppd_pkg::REFR_BITS'($urandom_range(0, 600)),
                  150, $urandom_range(0, 2) * 15, $urandom_range(0, 2) * 15);
      if (p == 2) begin
        // back up the output while the sender keeps offering
        @(posedge clk_i);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    end
    run_phase(ppd_pkg::RISE_BITS'($urandom_range(0, 100)),
              ppd_pkg::FALL_BITS'($urandom_range(0, 100)),
              ppd_pkg::MIN_AMP_BITS'($urandom_range(0, 500)),
              ppd_pkg::REFR_BITS'($urandom_range(0, 400)),
              300, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
